// ===== design/centered_moving_average_macros.svh =====
// Assertion macros used by the top-level RTL of the centered moving average.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef CENTERED_MOVING_AVERAGE_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_MACROS_SVH

`ifndef NO_ASSERTIONS

// When cond holds at a clock edge, expect holds at the same edge.
`define CMA_ASSERT_IMPLY(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("centered_moving_average: same-cycle check failed");

// When cond holds at a clock edge, expect holds at the next edge.
`define CMA_ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("centered_moving_average: next-cycle check failed");

`else

`define CMA_ASSERT_IMPLY(label, clk, rst, cond, expect_now)
`define CMA_ASSERT_NEXT(label, clk, rst, cond, expect_next)

`endif

`endif

// ===== design/cma_pkg.sv =====
`default_nettype none

package cma_pkg;

   // Width of the half_width register and its value after reset.
   localparam int HALF_BITS = 4;
   localparam logic [HALF_BITS-1:0] HALF_RESET = 4'd1;

   // Defaults for the top-level parameters.
   localparam int MAX_HALF_DEFAULT = 15;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Entries in the command queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Front-end sequencer states.
   typedef enum logic {
      FRONT_RUN,
      FRONT_FLUSH
   } front_state_type;

   // Fill status of the command queue.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== design/cma_front.sv =====
`default_nettype none

module cma_front
   import cma_pkg::*;
#(
   parameter int MAX_HALF = MAX_HALF_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int DEPTH = 2 * MAX_HALF + 2,
   localparam int CW = $clog2(DEPTH),
   localparam int SUMW = SAMPLE_BITS + CW
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [HALF_BITS-1:0]   half_width,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_final_sample,
   output logic                        cmd_valid,
   input  wire logic                   cmd_ready,
   output logic [SUMW-1:0]             cmd_sum,
   output logic [CW-1:0]               cmd_count,
   output logic                        cmd_last
);

   localparam int SW = $clog2(DEPTH + 1);

   // Ring of running totals: each slot holds the sequence sum up to that sample.
   logic [SUMW-1:0] ring [DEPTH];

   front_state_type state_ff, state_in;
   logic [CW-1:0]   head_ff, head_in;
   logic [SW-1:0]   seen_ff, seen_in;
   logic [SUMW-1:0] cum_ff, cum_in;
   logic [SW-1:0]   flush_d_ff, flush_d_in;
   logic [SW-1:0]   flush_h_ff, flush_h_in;

   // Read stage: one command waiting for its base total from the ring.
   logic            s1_valid_ff, s1_valid_in;
   logic [CW-1:0]   s1_count_ff;
   logic            s1_last_ff;
   logic [SUMW-1:0] s1_cum_ff;
   logic            s1_zero_ff;
   logic [SUMW-1:0] rd_ff;

   logic            s1_free;
   logic            ring_we;
   logic [SUMW-1:0] cum_new;
   logic [SW-1:0]   seen_new;
   logic [CW-1:0]   head_next;
   logic [SW-1:0]   h_sw;
   logic [SW-1:0]   win_run;
   logic [SW-1:0]   cnt_run;
   logic [SW-1:0]   win_fl;
   logic [SW-1:0]   cnt_fl;
   logic [SW-1:0]   m_minus1;
   logic            issue;
   logic [SW-1:0]   iss_count;
   logic            iss_last;
   logic [SUMW-1:0] iss_cum;
   logic [SW-1:0]   seen_ref;
   logic [CW-1:0]   last_slot;
   logic [CW:0]     addr_raw;
   logic [CW:0]     rd_addr;

   assign s1_free = !s1_valid_ff || cmd_ready;

   // Half width limited to what the ring can hold.
   always_comb begin
      if (int'(half_width) > MAX_HALF) begin
         h_sw = SW'(MAX_HALF);
      end else begin
         h_sw = SW'(half_width);
      end
   end

   // Bookkeeping for the incoming sample.
   assign cum_new   = cum_ff + {{CW{req_sample[SAMPLE_BITS-1]}}, req_sample};
   assign seen_new  = (seen_ff == SW'(DEPTH)) ? seen_ff : seen_ff + 1'b1;
   assign head_next = (head_ff == CW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Window lengths for a steady-state result and for a flush result.
   assign win_run  = (h_sw << 1) | SW'(1);
   assign cnt_run  = (seen_new < win_run) ? seen_new : win_run;
   assign m_minus1 = (seen_new > h_sw) ? h_sw : seen_new - 1'b1;
   assign win_fl   = flush_d_ff + flush_h_ff + SW'(1);
   assign cnt_fl   = (seen_ff < win_fl) ? seen_ff : win_fl;

   // Sequencer: accept samples, then walk out the flush results.
   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      seen_in    = seen_ff;
      cum_in     = cum_ff;
      flush_d_in = flush_d_ff;
      flush_h_in = flush_h_ff;
      req_ready  = 1'b0;
      ring_we    = 1'b0;
      issue      = 1'b0;
      iss_count  = seen_new;
      iss_last   = 1'b0;
      iss_cum    = cum_new;
      seen_ref   = seen_new;
      last_slot  = head_ff;
      unique case (state_ff)
         FRONT_RUN: begin
            req_ready = s1_free;
            if (req_valid && s1_free) begin
               ring_we = 1'b1;
               cum_in  = cum_new;
               seen_in = seen_new;
               head_in = head_next;
               if (req_final_sample) begin
                  state_in   = FRONT_FLUSH;
                  flush_d_in = m_minus1;
                  flush_h_in = h_sw;
               end else if (seen_new > h_sw) begin
                  issue     = 1'b1;
                  iss_count = cnt_run;
               end
            end
         end
         FRONT_FLUSH: begin
            seen_ref  = seen_ff;
            iss_cum   = cum_ff;
            iss_count = cnt_fl;
            last_slot = (head_ff == '0) ? CW'(DEPTH - 1) : head_ff - 1'b1;
            if (s1_free) begin
               issue    = 1'b1;
               iss_last = (flush_d_ff == '0);
               if (flush_d_ff == '0) begin
                  state_in = FRONT_RUN;
                  head_in  = '0;
                  seen_in  = '0;
                  cum_in   = '0;
               end else begin
                  flush_d_in = flush_d_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = FRONT_RUN;
         end
      endcase
   end

   // Slot that holds the total just before the window starts.
   always_comb begin
      addr_raw = (CW + 1)'(last_slot) + (CW + 1)'(DEPTH) - (CW + 1)'(iss_count);
      if (addr_raw >= (CW + 1)'(DEPTH)) begin
         rd_addr = addr_raw - (CW + 1)'(DEPTH);
      end else begin
         rd_addr = addr_raw;
      end
   end

   assign s1_valid_in = s1_free ? issue : s1_valid_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FRONT_RUN;
         head_ff     <= '0;
         seen_ff     <= '0;
         cum_ff      <= '0;
         flush_d_ff  <= '0;
         flush_h_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         seen_ff     <= seen_in;
         cum_ff      <= cum_in;
         flush_d_ff  <= flush_d_in;
         flush_h_ff  <= flush_h_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   // Read stage payload and the registered ring read.
   always_ff @(posedge clock) begin
      if (s1_free && issue) begin
         s1_count_ff <= iss_count[CW-1:0];
         s1_last_ff  <= iss_last;
         s1_cum_ff   <= iss_cum;
         s1_zero_ff  <= (iss_count == seen_ref);
         rd_ff       <= ring[rd_addr[CW-1:0]];
      end
   end

   // Ring write.
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring[head_ff] <= cum_new;
      end
   end

   // The window sum is the difference of two running totals.
   assign cmd_valid = s1_valid_ff;
   assign cmd_sum   = s1_cum_ff - (s1_zero_ff ? '0 : rd_ff);
   assign cmd_count = s1_count_ff;
   assign cmd_last  = s1_last_ff;

endmodule

`default_nettype wire

// ===== design/cma_queue.sv =====
`default_nettype none

module cma_queue
   import cma_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output queue_status_type      status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign status.full  = (fill_ff == NW'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/cma_back.sv =====
`default_nettype none

module cma_back
   import cma_pkg::*;
#(
   parameter int MAX_HALF = MAX_HALF_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   localparam int DEPTH = 2 * MAX_HALF + 2,
   localparam int CW = $clog2(DEPTH),
   localparam int SUMW = SAMPLE_BITS + CW
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   output logic                        cmd_ready,
   input  wire logic [SUMW-1:0]        cmd_sum,
   input  wire logic [CW-1:0]          cmd_count,
   input  wire logic                   cmd_last,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0]      rsp_average,
   output logic                        rsp_last_output
);

   localparam int STW = $clog2(SUMW + 1);

   logic                   busy_ff, busy_in;
   logic [STW-1:0]         step_ff, step_in;
   logic [CW-1:0]          rem_ff, rem_in;
   logic [SUMW-1:0]        quo_ff, quo_in;
   logic [CW-1:0]          div_ff;
   logic                   neg_ff;
   logic                   last_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_avg_ff;
   logic                   out_last_ff;

   logic                   start;
   logic                   finish;
   logic [CW:0]            trial;
   logic                   fits;
   logic [SUMW-1:0]        sum_mag;
   logic [SUMW-1:0]        quo_signed;

   assign cmd_ready = !busy_ff;
   assign start     = cmd_valid && !busy_ff;
   assign finish    = busy_ff && (step_ff == '0) && (!out_valid_ff || rsp_ready);
   assign sum_mag   = cmd_sum[SUMW-1] ? (~cmd_sum + 1'b1) : cmd_sum;

   // One restoring division step per cycle on the magnitude.
   assign trial = {rem_ff, quo_ff[SUMW-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STW'(SUMW);
         rem_in  = '0;
         quo_in  = sum_mag;
      end else if (busy_ff && (step_ff != '0)) begin
         step_in = step_ff - 1'b1;
         rem_in  = fits ? CW'(trial - {1'b0, div_ff}) : trial[CW-1:0];
         quo_in  = {quo_ff[SUMW-2:0], fits};
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   // Quotient sign restored; truncation toward zero follows from the magnitude.
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   // Output register parts the divider from the result channel.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Divider and result payload.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         div_ff  <= cmd_count;
         neg_ff  <= cmd_sum[SUMW-1];
         last_ff <= cmd_last;
      end
      if (finish) begin
         out_avg_ff  <= quo_signed[SAMPLE_BITS-1:0];
         out_last_ff <= last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_average     = out_avg_ff;
   assign rsp_last_output = out_last_ff;

endmodule

`default_nettype wire

// ===== design/centered_moving_average.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_sample, req_final_sample
// rsp       out        rsp_valid/rsp_ready   rsp_average, rsp_last_output
// csr       in         csr_wr_en             csr_wr_data (half_width)
//
// The front takes one sample per cycle unless a command waits on a full queue;
// a final sample holds req_ready low while the flush results are queued.
// The serial divider loads, runs one cycle per quotient bit and unloads, and
// takes no new command until its result has moved to the output register;
// a four-entry command queue lets the front run ahead.
// Reset is synchronous: counters clear, half_width returns to 1, no ring clearing.
`default_nettype none

`include "centered_moving_average_macros.svh"

module centered_moving_average
   import cma_pkg::*;
#(
   parameter int MAX_HALF = MAX_HALF_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                   req_final_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0]      rsp_average,
   output logic                        rsp_last_output,
   input  wire logic                   csr_wr_en,
   input  wire logic [HALF_BITS-1:0]   csr_wr_data
);

   localparam int DEPTH = 2 * MAX_HALF + 2;
   localparam int CW = $clog2(DEPTH);
   localparam int SUMW = SAMPLE_BITS + CW;
   localparam int QW = SUMW + CW + 1;

   logic [HALF_BITS-1:0] half_width_ff;

   logic                 cmd_valid;
   logic                 cmd_ready;
   logic [SUMW-1:0]      cmd_sum;
   logic [CW-1:0]        cmd_count;
   logic                 cmd_last;
   logic [QW-1:0]        q_out;
   queue_status_type     q_status;
   logic                 back_ready;
   logic                 q_pop;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= HALF_RESET;
      end else if (csr_wr_en) begin
         half_width_ff <= csr_wr_data;
      end
   end

   // Front end: ring of running totals and window bookkeeping.
   cma_front #(
      .MAX_HALF    (MAX_HALF),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .half_width       (half_width_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_final_sample (req_final_sample),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd_sum          (cmd_sum),
      .cmd_count        (cmd_count),
      .cmd_last         (cmd_last)
   );

   assign cmd_ready = !q_status.full;
   assign q_pop     = !q_status.empty && back_ready;

   // Command queue between front and divider.
   cma_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_valid),
      .push_data ({cmd_last, cmd_count, cmd_sum}),
      .pop       (q_pop),
      .pop_data  (q_out),
      .status    (q_status)
   );

   // Back end: serial divider and output register.
   cma_back #(
      .MAX_HALF    (MAX_HALF),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (!q_status.empty),
      .cmd_ready       (back_ready),
      .cmd_sum         (q_out[SUMW-1:0]),
      .cmd_count       (q_out[SUMW+CW-1:SUMW]),
      .cmd_last        (q_out[QW-1]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_average     (rsp_average),
      .rsp_last_output (rsp_last_output)
   );

   // A final sample always starts a flush, so input stalls on the next cycle.
   `CMA_ASSERT_NEXT(a_final_stalls, clock, reset, req_valid && req_ready && req_final_sample, !req_ready)
   // The queue fill count never claims full and empty together.
   `CMA_ASSERT_IMPLY(a_queue_status, clock, reset, q_status.full, !q_status.empty)
   // A command handed to the divider keeps it busy on the following cycle.
   `CMA_ASSERT_NEXT(a_back_busy, clock, reset, q_pop, !back_ready)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
   import cma_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_HALF     = MAX_HALF_DEFAULT;
   localparam int SAMPLE_BITS  = SAMPLE_BITS_DEFAULT;
   localparam int RING_DEPTH   = 2 * MAX_HALF + 2;
   localparam int DRAIN_CYCLES = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 600000;

   // One input transaction and one smoothed result.
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          final_sample;
   } sample_txn_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] average;
      logic                          last_output;
   } mean_txn_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   req_final_sample = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_average;
   logic                   rsp_last_output;
   logic                   csr_wr_en = 1'b0;
   logic [HALF_BITS-1:0]   csr_wr_data = '0;

   centered_moving_average #(
      .MAX_HALF(MAX_HALF),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_sample(req_sample),
      .req_final_sample(req_final_sample),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_average(rsp_average),
      .rsp_last_output(rsp_last_output),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // Stimulus queue, expected results and run statistics.
   sample_txn_type sample_queue[$];
   mean_txn_type   expected_means[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        rsp_hold;
   logic        hold_request = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_count = 0;
   logic        req_accepted = 1'b0;
   int unsigned error_count = 0;
   int unsigned samples_taken = 0;
   int unsigned sequences_done = 0;
   int unsigned means_checked = 0;
   int unsigned cycle_count = 0;
   logic [15:0] halves_used = '0;

   // Shadow state of the smoothing window.
   logic [HALF_BITS-1:0]          cur_half = HALF_RESET;
   logic signed [SAMPLE_BITS-1:0] window_samples [RING_DEPTH];
   logic [4:0]                    wr_slot = '0;
   int unsigned                   seq_len = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Mean of the most recent span samples, queued as one expected result.
   function automatic void push_window_mean(input int span, input logic is_last);
      int        total;
      logic [4:0] idx;
      mean_txn_type m;
      total = 0;
      if (span == 0) span = 1;
      for (int j = 0; j < span; j++) begin
         idx = 5'(int'(wr_slot) - 1 - j);
         total += window_samples[idx];
      end
      m.average = SAMPLE_BITS'(total / span);
      m.last_output = is_last;
      expected_means.insert(expected_means.size(), m);
   endfunction

   // Works out every result caused by one accepted sample.
   function automatic void predict_means(input sample_txn_type txn);
      int h, flush_n, reach;
      h = (int'(cur_half) > MAX_HALF) ? MAX_HALF : int'(cur_half);
      window_samples[wr_slot] = txn.sample;
      wr_slot = wr_slot + 5'd1;
      if (seq_len < RING_DEPTH) seq_len++;
      if (!txn.final_sample) begin
         if (seq_len >= h + 1)
            push_window_mean((seq_len < 2 * h + 1) ? seq_len : 2 * h + 1, 1'b0);
      end else begin
         // The final sample flushes every centre not yet emitted.
         flush_n = (seq_len < h + 1) ? seq_len : h + 1;
         for (int k = 0; k < flush_n; k++) begin
            reach = (flush_n - 1 - k) + h + 1;
            push_window_mean((seq_len < reach) ? seq_len : reach, k + 1 == flush_n);
         end
         seq_len = 0;
         wr_slot = '0;
         sequences_done++;
      end
   endfunction

   // Input capture: every accepted transaction goes through the predictor.
   always @(posedge clock) begin
      req_accepted = !reset && req_valid && req_ready;
      if (req_accepted) begin
         predict_means({req_sample, req_final_sample});
         samples_taken++;
      end
   end

   // Driver: presents the next pending sample once the previous one is taken.
   always @(negedge clock) begin
      logic           offer;
      sample_txn_type txn;
      if (!reset && (!req_valid || req_accepted)) begin
         offer = (sample_queue.size() > 0) && ($urandom_range(99) >= send_idle_pct);
         if (offer) begin
            txn = sample_queue.pop_front();
            req_sample <= txn.sample;
            req_final_sample <= txn.final_sample;
         end
         req_valid <= offer;
      end
   end

   // Long receiver hold-off, timed here once requested.
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         hold_count <= hold_count + 1;
         if (hold_count + 1 >= HOLD_CYCLES)
            hold_done <= 1'b1;
      end
   end

   assign rsp_hold = hold_request && !hold_done;

   // Receiver backpressure.
   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: each result transaction is compared with the oldest expectation.
   always @(posedge clock) begin
      mean_txn_type exp_mean;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_means.size() == 0) begin
            report_mismatch($sformatf("unexpected result average=%0d last=%0b",
                                      $signed(rsp_average), rsp_last_output));
         end else begin
            exp_mean = expected_means.pop_front();
            if (rsp_average !== exp_mean.average)
               report_mismatch($sformatf("average got %0d, want %0d",
                                         $signed(rsp_average), exp_mean.average));
            if (rsp_last_output !== exp_mean.last_output)
               report_mismatch($sformatf("last_output got %0b, want %0b",
                                         rsp_last_output, exp_mean.last_output));
         end
         means_checked++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(3))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return 16'shFFFF;
         endcase
      end
      if (pick < 40) return SAMPLE_BITS'($urandom_range(1023)) - 16'sd512;
      return SAMPLE_BITS'($urandom);
   endfunction

   function automatic void push_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                       input logic is_last);
      sample_queue.insert(sample_queue.size(), {s, is_last});
   endfunction

   function automatic void queue_sequence(input int len);
      for (int i = 0; i < len; i++)
         push_sample(random_sample(), i == len - 1);
   endfunction

   // Sender pauses until every result is back and the block has settled.
   task automatic wait_drained();
      while (sample_queue.size() != 0 || req_valid || expected_means.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Register write; only issued while the block is idle.
   task automatic write_half(input logic [HALF_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_half = value;
      halves_used[value] = 1'b1;
   endtask

   // Queues random sequences of mostly short length, now and then a long one
   // that can wrap the sample ring.
   task automatic random_block(input logic [HALF_BITS-1:0] half, input int target);
      int queued;
      int len;
      write_half(half);
      queued = 0;
      while (queued < target) begin
         len = ($urandom_range(99) < 15) ? $urandom_range(30, 70) : $urandom_range(1, 12);
         queue_sequence(len);
         queued += len;
      end
      wait_drained();
   endtask

   initial begin
      logic [HALF_BITS-1:0] half;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      halves_used[HALF_RESET] = 1'b1;

      // Directed: single-sample sequence at the reset half width.
      push_sample(16'sh7FFF, 1'b1);
      // Field extremes with a shrinking window at both ends.
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh0000, 1'b0);
      push_sample(16'shFFFF, 1'b1);
      wait_drained();

      // Half width zero passes samples through unchanged.
      write_half(4'd0);
      push_sample(16'sh0001, 1'b0);
      push_sample(16'shFFFF, 1'b0);
      push_sample(16'sh8000, 1'b1);
      wait_drained();

      // Widest window: the whole short sequence stays in warm-up until flushed.
      write_half(4'd15);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh7FFF, 1'b0);
      push_sample(16'sh8000, 1'b0);
      push_sample(16'sh0003, 1'b1);
      wait_drained();

      // Half width changed in the middle of a sequence.
      write_half(4'd2);
      for (int i = 0; i < 6; i++) push_sample(random_sample(), 1'b0);
      wait_drained();
      write_half(4'd4);
      push_sample(random_sample(), 1'b0);
      push_sample(random_sample(), 1'b0);
      push_sample(random_sample(), 1'b1);
      wait_drained();

      // Random phases: no idling, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = (phase == 1) ? 66 : (phase == 3) ? 33 : 0;
         recv_stall_pct = (phase == 2) ? 66 : (phase == 3) ? 33 : 0;
         for (int sub = 0; sub < 4; sub++) begin
            half = (sub == 0) ? 4'd0 : (sub == 1) ? 4'd15 : HALF_BITS'($urandom_range(15));
            random_block(half, 8);
         end
      end

      // Long receiver hold-off while the sender keeps offering samples.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_half(4'd3);
      hold_request = 1'b1;
      queue_sequence(40);
      queue_sequence(20);
      wait (hold_done);
      hold_request = 1'b0;
      wait_drained();

      if (expected_means.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_means.size()));
      $display("Covered %0d samples in %0d sequences, %0d results checked, %0d half widths",
               samples_taken, sequences_done, means_checked, $countones(halves_used));
      $display("Included idle and stall phases, a long receiver hold-off and %0d mismatches",
               error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
